FILE: hw/rtl/acet_pkg.sv
// Shared types and codes for the box contact event tracker.
package acet_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned SIZE_W  = 23;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_MISSING = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOX     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ID_W-1:0]           left_id;
    logic [ID_W-1:0]           right_id;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic [SIZE_W-1:0]         left_width;
    logic [SIZE_W-1:0]         left_height;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic [SIZE_W-1:0]         right_width;
    logic [SIZE_W-1:0]         right_height;
  } in_req_t;

  typedef struct packed {
    contact_event_t  contact_event;
    logic            overlapping;
    logic [ID_W-1:0] pair_left;
    logic [ID_W-1:0] pair_right;
  } out_rsp_t;

endpackage

FILE: hw/rtl/acet_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module acet_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/acet_overlap.sv
// Strict axis-aligned overlap test of two boxes.
module acet_overlap (
  input  acet_pkg::in_req_t req,
  output logic              hit
);

  localparam int unsigned SUM_W = acet_pkg::COORD_W + 1;

  logic signed [SUM_W-1:0] lx, ly, rx, ry;
  logic signed [SUM_W-1:0] lw, lh, rw, rh;
  logic signed [SUM_W-1:0] l_right, l_bottom, r_right, r_bottom;

  // Edges are widened by one bit so the sums never wrap.
  assign lx = $signed({req.left_x[acet_pkg::COORD_W-1], req.left_x});
  assign ly = $signed({req.left_y[acet_pkg::COORD_W-1], req.left_y});
  assign rx = $signed({req.right_x[acet_pkg::COORD_W-1], req.right_x});
  assign ry = $signed({req.right_y[acet_pkg::COORD_W-1], req.right_y});
  assign lw = $signed({2'b00, req.left_width});
  assign lh = $signed({2'b00, req.left_height});
  assign rw = $signed({2'b00, req.right_width});
  assign rh = $signed({2'b00, req.right_height});

  assign l_right  = lx + lw;
  assign l_bottom = ly + lh;
  assign r_right  = rx + rw;
  assign r_bottom = ry + rh;

  assign hit = (lx < r_right) && (l_right > rx) && (ly < r_bottom) && (l_bottom > ry);

endmodule

FILE: hw/rtl/aabb_contact_event_tracker_core.sv
// Top level of the box contact event tracker: contact bit table and event logic.
//
//   Channel | Ports                        | Direction | Payload
//   --------+------------------------------+-----------+-----------------------
//   input   | in_valid, in_stall, in_req   | in        | acet_pkg::in_req_t
//   result  | out_valid, out_stall, out_rsp| out       | acet_pkg::out_rsp_t
//
// One request per cycle is taken in steady state, while out_stall is low. A request
// is held in the lookup stage register while the contact bit RAM reads, and its result
// then enters the output register, which drives out_valid.
// After reset the RAM is cleared one entry per cycle, all COLLIDER_IDS*COLLIDER_IDS
// entries (4096 at the default), and in_stall stays high during that pass.
// A stalled result holds the output register; one more request may sit in the
// lookup stage behind it before in_stall rises.
module aabb_contact_event_tracker_core #(
  parameter int unsigned COLLIDER_IDS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  acet_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output acet_pkg::out_rsp_t out_rsp
);

  localparam int unsigned DEPTH = COLLIDER_IDS * COLLIDER_IDS;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  acet_pkg::in_req_t s1_req_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_in_range_r;
  logic              fwd_r, fwd_nxt;
  logic              fwd_val_r;

  logic               out_valid_r, out_valid_nxt;
  acet_pkg::out_rsp_t out_rsp_r;

  logic              in_acc, s1_adv, clearing;
  logic [IDX_W-1:0]  in_idx;
  logic              in_in_range;
  logic              box_hit, ovl, upd, was;
  acet_pkg::contact_event_t ev;

  logic              wr_en, wr_data;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_data;

  assign clearing = (state_r == ST_CLEAR);
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  assign in_in_range = (int'(in_req.left_id) < COLLIDER_IDS) &&
                       (int'(in_req.right_id) < COLLIDER_IDS);
  assign in_idx = IDX_W'(int'(in_req.left_id) * COLLIDER_IDS + int'(in_req.right_id));

  acet_overlap u_overlap (
    .req (s1_req_r),
    .hit (box_hit)
  );

  assign ovl = (s1_req_r.kind == acet_pkg::KIND_BOX) && box_hit;
  assign upd = (s1_req_r.kind != acet_pkg::KIND_MISSING) && s1_in_range_r;
  // The entry written in the cycle a request is taken reads stale from the RAM.
  assign was = fwd_r ? fwd_val_r : rd_data;

  always_comb begin
    priority if (!upd) begin
      ev = acet_pkg::EV_NONE;
    end else if (ovl) begin
      ev = was ? acet_pkg::EV_STAY : acet_pkg::EV_ENTER;
    end else begin
      ev = was ? acet_pkg::EV_EXIT : acet_pkg::EV_NONE;
    end
  end

  assign wr_en   = clearing || (s1_adv && upd);
  assign wr_addr = clearing ? clr_cnt_r : s1_idx_r;
  assign wr_data = clearing ? 1'b0 : ovl;

  acet_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_contact_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_cnt_nxt = clr_cnt_r;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign fwd_nxt       = s1_adv && upd && (s1_idx_r == in_idx);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r      <= in_req;
      s1_idx_r      <= in_idx;
      s1_in_range_r <= in_in_range;
      fwd_r         <= fwd_nxt;
      fwd_val_r     <= ovl;
    end
    if (s1_adv) begin
      out_rsp_r.contact_event <= ev;
      out_rsp_r.overlapping   <= ovl;
      out_rsp_r.pair_left     <= s1_req_r.left_id;
      out_rsp_r.pair_right    <= s1_req_r.right_id;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
